### rtl/eqmd_pkg.sv
// ----------------------------------------------------------------------------
// eqmd_pkg
// Shared types and constants for the event queue with subscriber dispatch.
// ----------------------------------------------------------------------------
`default_nettype none

package eqmd_pkg;

  localparam int QUEUE_SLOTS = 16;
  localparam int SUBSCRIBERS = 8;
  localparam int EVENT_W     = 16;
  localparam int PAYLOAD_W   = 32;
  localparam int STATUS_W    = 3;
  localparam int DEPTH_W     = 4;
  localparam int SUB_W       = 3;
  localparam int PTR_W       = $clog2(QUEUE_SLOTS);
  localparam int ENTRY_W     = EVENT_W + PAYLOAD_W;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 56;

  localparam logic OP_POST     = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STS_POSTED    = 3'd0,
    STS_DROPPED   = 3'd1,
    STS_EMPTY     = 3'd2,
    STS_DELIVERED = 3'd3,
    STS_NOMATCH   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SINGLE,
    ST_READ,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // configuration write transaction toward the mask bank
  typedef struct packed {
    logic             valid;
    logic [SUB_W-1:0] index;
    logic [EVENT_W-1:0] data;
  } cfg_wr_t;

endpackage

`default_nettype wire

### rtl/eqmd_ram.sv
// ----------------------------------------------------------------------------
// eqmd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module eqmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/eqmd_sub_scan.sv
// ----------------------------------------------------------------------------
// eqmd_sub_scan
// Subscriber mask bank with one shared mask/event overlap compare.
// ----------------------------------------------------------------------------
`default_nettype none

module eqmd_sub_scan
  import eqmd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cfg_wr_t            cfg,
  input  wire logic [SUB_W-1:0]   sel,
  input  wire logic [EVENT_W-1:0] ev,
  output      logic               hit
);

  logic [EVENT_W-1:0] masks [SUBSCRIBERS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SUBSCRIBERS; i++) begin
        masks[i] <= '0;
      end
    end else if (cfg.valid) begin
      masks[cfg.index] <= cfg.data;
    end
  end

  // one subscriber per cycle unless the output stalls; a zero mask never overlaps
  assign hit = |(masks[sel] & ev);

endmodule

`default_nettype wire

### rtl/event_queue_mask_dispatch.sv
// Sequence: a post, or a dispatch on an empty queue, goes from accept to a
// single result; a dispatch with events goes from accept through a store
// read and the 8 subscriber compares in the shared unit to a closing result.
// One transaction is in flight at a time; s_tready is high only when idle.
// Output stalls hold the subscriber scan until the output register is free.
// Reset: rst synchronous active high; clears pointers, masks and control.
// ----------------------------------------------------------------------------
// event_queue_mask_dispatch
// Ring-buffer event queue; dispatch pops the oldest event and delivers it to
// every subscriber whose mask overlaps the event bits.
// ----------------------------------------------------------------------------
`default_nettype none

module event_queue_mask_dispatch
  import eqmd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input stream
  input  wire logic                  s_tvalid,
  output      logic                  s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] event_bits, [47:16] payload
  input  wire logic                  s_tuser,   // [0] op
  // result stream
  output      logic                  m_tvalid,
  input  wire logic                  m_tready,
  output      logic [OUT_DATA_W-1:0] m_tdata,   // [2:0] subscriber, [18:3] out_event,
                                                // [50:19] out_payload, [54:51] depth, pad
  output      logic [STATUS_W-1:0]   m_tuser,   // [2:0] status
  output      logic                  m_tlast,
  // configuration writes
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [SUB_W-1:0]      cfg_index,
  input  wire logic [EVENT_W-1:0]    cfg_data
);

  state_t state, state_next;

  logic [PTR_W-1:0] wp, rp, wp_inc, rp_inc;
  logic             q_empty, q_full;
  logic [PTR_W:0]   depth_wide;

  logic [EVENT_W-1:0]   cur_ev;
  logic [PAYLOAD_W-1:0] cur_data;
  status_t              single_sts;
  logic [SUB_W-1:0]     idx;
  logic                 has_pend;
  logic [SUB_W-1:0]     pend_idx;

  logic                 s_acc, is_post, out_free, hit;
  logic [ENTRY_W-1:0]   ram_rdata;

  // output register
  status_t              o_sts;
  logic [SUB_W-1:0]     o_sub;
  logic [EVENT_W-1:0]   o_ev;
  logic [PAYLOAD_W-1:0] o_data;
  logic [DEPTH_W-1:0]   o_depth;
  logic                 o_last;

  // load controls
  logic                 load, scan_step;
  status_t              ld_sts;
  logic [SUB_W-1:0]     ld_sub;
  logic [EVENT_W-1:0]   ld_ev;
  logic [PAYLOAD_W-1:0] ld_data;
  logic                 ld_last;

  cfg_wr_t cfg;

  assign s_acc    = s_tvalid && s_tready;
  assign is_post  = (s_tuser == OP_POST);
  assign out_free = !m_tvalid || m_tready;

  assign wp_inc  = (wp == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : wp + 1'b1;
  assign rp_inc  = (rp == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : rp + 1'b1;
  assign q_empty = (wp == rp);
  assign q_full  = (wp_inc == rp);

  assign depth_wide = (wp >= rp) ? {1'b0, wp} - {1'b0, rp}
                                 : {1'b0, wp} + (PTR_W+1)'(QUEUE_SLOTS) - {1'b0, rp};

  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  eqmd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (s_acc && is_post && !q_full),
    .waddr (wp),
    .wdata ({s_tdata[47:16], s_tdata[15:0]}),
    .re    (s_acc && !is_post && !q_empty),
    .raddr (rp),
    .rdata (ram_rdata)
  );

  eqmd_sub_scan u_scan (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .sel (idx),
    .ev  (cur_ev),
    .hit (hit)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_acc) begin
          if (is_post || q_empty) begin
            state_next = ST_SINGLE;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_SINGLE: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_READ: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (out_free && idx == SUB_W'(SUBSCRIBERS - 1)) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready  = 1'b0;
    load      = 1'b0;
    scan_step = 1'b0;
    ld_sts    = single_sts;
    ld_sub    = '0;
    ld_ev     = '0;
    ld_data   = '0;
    ld_last   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_SINGLE: begin
        load = out_free;
      end
      ST_READ: ;
      ST_SCAN: begin
        scan_step = out_free;
        // a new hit pushes the previous one out, not the last
        load      = out_free && hit && has_pend;
        ld_sts    = STS_DELIVERED;
        ld_sub    = pend_idx;
        ld_ev     = cur_ev;
        ld_data   = cur_data;
        ld_last   = 1'b0;
      end
      ST_FINISH: begin
        load    = out_free;
        ld_sts  = has_pend ? STS_DELIVERED : STS_NOMATCH;
        ld_sub  = has_pend ? pend_idx : '0;
        ld_ev   = cur_ev;
        ld_data = cur_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      wp       <= '0;
      rp       <= '0;
      m_tvalid <= 1'b0;
      has_pend <= 1'b0;
      idx      <= '0;
    end else begin
      state <= state_next;
      if (s_acc) begin
        idx      <= '0;
        has_pend <= 1'b0;
        if (is_post) begin
          single_sts <= q_full ? STS_DROPPED : STS_POSTED;
          if (!q_full) wp <= wp_inc;
        end else begin
          single_sts <= STS_EMPTY;
          if (!q_empty) rp <= rp_inc;
        end
      end
      if (state == ST_READ) begin
        cur_ev   <= ram_rdata[EVENT_W-1:0];
        cur_data <= ram_rdata[ENTRY_W-1:EVENT_W];
      end
      if (scan_step) begin
        if (hit) begin
          has_pend <= 1'b1;
          pend_idx <= idx;
        end
        if (idx != SUB_W'(SUBSCRIBERS - 1)) idx <= idx + 1'b1;
      end
      // closing result leaves with the pending delivery
      if (state == ST_FINISH && load) begin
        has_pend <= 1'b0;
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_sts   <= ld_sts;
      o_sub   <= ld_sub;
      o_ev    <= ld_ev;
      o_data  <= ld_data;
      o_last  <= ld_last;
      o_depth <= DEPTH_W'(depth_wide);
    end
  end

  assign m_tdata = {1'b0, o_depth, o_data, o_ev, o_sub};
  assign m_tuser = o_sts;
  assign m_tlast = o_last;

  // only deliveries may be non-final results
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != STS_DELIVERED) |-> m_tlast)
    else $error("non-delivery result without tlast");

  // an accepted post into a ring with room advances the write pointer
  a_post_adv: assert property (@(posedge clk) disable iff (rst)
    (s_acc && is_post && !q_full) |=> (wp != $past(wp)))
    else $error("post did not advance write pointer");

  // no pending delivery may survive into the idle state
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !has_pend || $past(state) == ST_FINISH)
    else $error("stale pending delivery in idle");

  // a dispatch that pops an event is never taken on an empty ring
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> ($past(s_acc) && !$past(q_empty)))
    else $error("store read without a queued event");

endmodule

`default_nettype wire
